// ----- src/phc_pkg.sv -----
`timescale 1ns / 1ps
package phc_pkg;

	localparam int CordicStepsDef = 16;
	localparam int AngW = 36;
	localparam int VecW = 36;
	localparam logic signed [AngW-1:0] Pi30 = 36'sd3373259426;
	localparam logic [23:0] InvK24 = 24'd10187994;
	localparam logic signed [15:0] HeadMax = 16'sd25736;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic               end_of_path;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] heading;
		logic [15:0]        curvature;
		logic               last_result;
	} out_word_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load_in;     // capture input word
		logic vec_start;   // init CORDIC for segment
		logic vec_sel;     // 0: older->newer, 1: newer->point
		logic vec_step;    // one CORDIC iteration
		logic vec_save_in; // store result as incoming segment
		logic vec_save_out;
		logic len_mul;     // length scale multiply
		logic div_start;
		logic div_step;
		logic shift_pts;   // update stored points
		logic clr_pts;
	} phc_cmd_t;

	typedef struct packed {
		logic step_last;
		logic div_last;
		logic end_flag;
	} phc_sts_t;

	// Q30 atan(2^-i)
	function automatic logic signed [AngW-1:0] atan_tab(input logic [4:0] i);
		logic signed [AngW-1:0] r;
		case (i)
			5'd0: r = 36'sd843314857;
			5'd1: r = 36'sd497837829;
			5'd2: r = 36'sd263043837;
			5'd3: r = 36'sd133525159;
			5'd4: r = 36'sd67021687;
			5'd5: r = 36'sd33543516;
			5'd6: r = 36'sd16775851;
			5'd7: r = 36'sd8388437;
			5'd8: r = 36'sd4194283;
			5'd9: r = 36'sd2097149;
			5'd10: r = 36'sd1048576;
			5'd11: r = 36'sd524288;
			5'd12: r = 36'sd262144;
			5'd13: r = 36'sd131072;
			5'd14: r = 36'sd65536;
			5'd15: r = 36'sd32768;
			5'd16: r = 36'sd16384;
			5'd17: r = 36'sd8192;
			5'd18: r = 36'sd4096;
			5'd19: r = 36'sd2048;
			5'd20: r = 36'sd1024;
			5'd21: r = 36'sd512;
			5'd22: r = 36'sd256;
			5'd23: r = 36'sd128;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- src/path_heading_curvature.sv -----
`timescale 1ns / 1ps
// Each point after the second runs two sequential passes of one CORDIC unit
// and a 37-step serial divider, then emits its words; no new point is taken
// until the block is back in idle and all of its output words have gone out.
// The first point of a path skips both; the second takes a single CORDIC pass.
// Reset (arst_n low) clears the path state; the block then waits for a point.
module path_heading_curvature #(
	parameter int CORDIC_STEPS = phc_pkg::CordicStepsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  phc_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output phc_pkg::out_word_t out_data
);
	phc_pkg::phc_cmd_t cmd;
	phc_pkg::phc_sts_t sts;
	logic [1:0] seen, emit_sel;
	logic emit_last, emit_zero;
	logic signed [15:0] held_head, head_out;
	logic [15:0] curv;

	phc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.sts, .cmd, .seen, .emit_sel, .emit_last, .emit_zero
	);

	phc_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk, .arst_n, .in_word(in_data), .cmd, .seen, .sts,
		.held_head, .head_out, .curv
	);

	// output word select
	always_comb begin
		out_data.heading = emit_zero ? 16'sd0 : ((emit_sel == 2'd0) ? held_head : head_out);
		out_data.curvature = curv;
		out_data.last_result = emit_last;
	end
endmodule

// ----- src/phc_datapath.sv -----
`timescale 1ns / 1ps
module phc_datapath #(
	parameter int CORDIC_STEPS = phc_pkg::CordicStepsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  phc_pkg::in_word_t   in_word,
	input  phc_pkg::phc_cmd_t   cmd,
	input  logic [1:0]          seen,
	output phc_pkg::phc_sts_t   sts,
	output logic signed [15:0]  held_head,
	output logic signed [15:0]  head_out,
	output logic [15:0]         curv
);
	localparam int AW = phc_pkg::AngW;
	localparam int VW = phc_pkg::VecW;
	localparam int SW = $clog2(CORDIC_STEPS + 1);

	logic signed [31:0] px_q, py_q, ox_q, oy_q, nx_q, ny_q;
	logic               last_q;
	logic signed [VW-1:0] x_q, y_q;
	logic signed [AW-1:0] z_q, a_in_q, a_out_q;
	logic [SW-1:0]      it_q;
	logic               zero_in_q, zero_out_q, zero_cur_q;
	logic [33:0]        l_in_q, l_out_q;
	logic [15:0]        held_head_q, head_out_q;
	logic [57:0]        prod_q;

	// divider: (d + 4S) / 8S, restoring
	logic [36:0] dvd_q, dvs_q;
	logic [36:0] rem_q;
	logic [5:0]  dcnt_q;
	logic [36:0] quo_q;

	logic signed [32:0] dx, dy;
	logic signed [VW-1:0] xs, ys;
	logic [4:0] it5;
	logic signed [AW-1:0] d0, d1, dabs;
	logic [33:0] ssum;
	logic [37:0] rtry;
	logic signed [AW-1:0] zr;
	logic signed [15:0] hq;

	always_comb begin
		if (!cmd.vec_sel) begin
			dx = 33'(nx_q) - 33'(ox_q);
			dy = 33'(ny_q) - 33'(oy_q);
		end else begin
			dx = 33'(px_q) - 33'(nx_q);
			dy = 33'(py_q) - 33'(ny_q);
		end
		it5 = 5'(it_q);
		xs = x_q >>> it_q;
		ys = y_q >>> it_q;
	end

	// Q30 to Q3.13 heading, round half up, clamp
	function automatic logic signed [15:0] to_q13(input logic signed [AW-1:0] a);
		logic signed [AW-1:0] h;
		h = (a + AW'(65536)) >>> 17;
		if (h > AW'(phc_pkg::HeadMax)) h = AW'(phc_pkg::HeadMax);
		if (h < -AW'(phc_pkg::HeadMax)) h = -AW'(phc_pkg::HeadMax);
		return h[15:0];
	endfunction

	assign zr = zero_cur_q ? '0 : z_q;
	assign hq = to_q13(zr);

	// turning angle
	always_comb begin
		d0 = a_out_q - a_in_q;
		d1 = d0;
		if (d0 > phc_pkg::Pi30) d1 = d0 - (phc_pkg::Pi30 <<< 1);
		if (d0 < -phc_pkg::Pi30) d1 = d0 + (phc_pkg::Pi30 <<< 1);
		dabs = (d1 < 0) ? -d1 : d1;
		ssum = l_in_q + l_out_q;
		if (ssum == '0) ssum = 34'd1;
		rtry = {rem_q, dvd_q[36]} - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q <= '0;
			dcnt_q <= '0;
			ox_q <= '0; oy_q <= '0; nx_q <= '0; ny_q <= '0;
			held_head_q <= '0;
		end else begin
			if (cmd.vec_start) it_q <= '0;
			else if (cmd.vec_step) it_q <= it_q + SW'(1);
			if (cmd.div_start) dcnt_q <= '0;
			else if (cmd.div_step) dcnt_q <= dcnt_q + 6'd1;
			if (cmd.vec_save_in && seen == 2'd1) held_head_q <= hq;
			if (cmd.clr_pts) begin
				ox_q <= '0; oy_q <= '0; nx_q <= '0; ny_q <= '0;
			end else if (cmd.shift_pts) begin
				ox_q <= nx_q; oy_q <= ny_q;
				nx_q <= px_q; ny_q <= py_q;
				if (seen != 2'd1) held_head_q <= head_out_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			px_q <= in_word.point_x;
			py_q <= in_word.point_y;
			last_q <= in_word.end_of_path;
		end
		// CORDIC vectoring
		if (cmd.vec_start) begin
			zero_cur_q <= (dx == '0) && (dy == '0);
			if (dx < 0) begin
				x_q <= -VW'(dx);
				y_q <= -VW'(dy);
				z_q <= (dy >= 0) ? phc_pkg::Pi30 : -phc_pkg::Pi30;
			end else begin
				x_q <= VW'(dx);
				y_q <= VW'(dy);
				z_q <= '0;
			end
		end else if (cmd.vec_step) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + phc_pkg::atan_tab(it5);
			end else begin
				x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - phc_pkg::atan_tab(it5);
			end
		end
		if (cmd.len_mul) prod_q <= x_q[33:0] * phc_pkg::InvK24;
		if (cmd.vec_save_in) begin
			a_in_q <= zr;
			zero_in_q <= zero_cur_q;
			l_in_q <= zero_cur_q ? '0 : 34'((prod_q + 58'(1 << 23)) >> 24);
		end
		if (cmd.vec_save_out) begin
			a_out_q <= zr;
			zero_out_q <= zero_cur_q;
			l_out_q <= zero_cur_q ? '0 : 34'((prod_q + 58'(1 << 23)) >> 24);
			head_out_q <= hq;
		end
		if (cmd.div_start) begin
			dvd_q <= 37'(dabs) + 37'({ssum, 2'b00});
			dvs_q <= 37'({ssum, 3'b000});
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[35:0], 1'b0};
			if (!rtry[37]) begin
				rem_q <= rtry[36:0];
				quo_q <= {quo_q[35:0], 1'b1};
			end else begin
				rem_q <= {rem_q[35:0], dvd_q[36]};
				quo_q <= {quo_q[35:0], 1'b0};
			end
		end
	end

	assign sts.step_last = (it_q == SW'(CORDIC_STEPS - 1));
	assign sts.div_last = (dcnt_q == 6'd36);
	assign sts.end_flag = last_q;
	assign held_head = held_head_q;
	assign head_out = head_out_q;
	assign curv = (zero_in_q || zero_out_q || seen != 2'd2 && seen != 2'd3) ? 16'd0 :
		((quo_q[36:16] != '0) ? 16'hFFFF : quo_q[15:0]);
endmodule

// ----- src/phc_ctrl.sv -----
`timescale 1ns / 1ps
module phc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  phc_pkg::phc_sts_t sts,
	output phc_pkg::phc_cmd_t cmd,
	output logic [1:0]        seen,
	output logic [1:0]        emit_sel, // 0 held, 1 new
	output logic              emit_last,
	output logic              emit_zero
);
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_VST  = 9'b000000010,
		S_VIT  = 9'b000000100,
		S_MUL  = 9'b000001000,
		S_SAVE = 9'b000010000,
		S_DST  = 9'b000100000,
		S_DIV  = 9'b001000000,
		S_EMIT = 9'b010000000,
		S_UPD  = 9'b100000000
	} st_t;

	st_t st_q;
	logic [1:0] seen_q;
	logic       seg_q; // which segment in flight
	logic [1:0] emit_q;

	assign seen = seen_q;
	assign in_ready = (st_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load_in = in_valid && (st_q == S_IDLE);
		// second point: its only segment runs from the stored point to the new one
		cmd.vec_sel = seg_q || (seen_q == 2'd1);
		cmd.vec_start = (st_q == S_VST);
		cmd.vec_step = (st_q == S_VIT);
		cmd.len_mul = (st_q == S_MUL);
		cmd.vec_save_in = (st_q == S_SAVE) && !seg_q;
		cmd.vec_save_out = (st_q == S_SAVE) && seg_q;
		cmd.div_start = (st_q == S_DST);
		cmd.div_step = (st_q == S_DIV);
		cmd.shift_pts = (st_q == S_UPD) && !sts.end_flag;
		cmd.clr_pts = (st_q == S_UPD) && sts.end_flag;
		out_valid = (st_q == S_EMIT);
		// result list per case
		emit_zero = (seen_q == 2'd0);
		emit_last = 1'b0;
		emit_sel = 2'd1;
		unique case (seen_q)
			2'd0: begin emit_sel = 2'd0; emit_last = 1'b1; end
			2'd1: begin emit_sel = 2'd0; emit_last = (emit_q == 2'd1); end
			2'd2: begin
				emit_sel = (emit_q == 2'd0) ? 2'd0 : 2'd1;
				emit_last = (emit_q == 2'd2);
			end
			default: begin emit_sel = 2'd1; emit_last = (emit_q == 2'd1); end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			seen_q <= '0;
			seg_q <= 1'b0;
			emit_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						emit_q <= '0;
						seg_q <= (seen_q == 2'd1) ? 1'b0 : 1'b1;
						if (seen_q == 2'd0) st_q <= S_UPD;
						else st_q <= (seen_q == 2'd1) ? S_UPD : S_VST;
						if (seen_q == 2'd1) st_q <= S_VST;
						if (seen_q >= 2'd2) seg_q <= 1'b0;
					end
				end
				S_VST: st_q <= S_VIT;
				S_VIT: if (sts.step_last) st_q <= S_MUL;
				S_MUL: st_q <= S_SAVE;
				S_SAVE: begin
					if (seen_q == 2'd1) st_q <= S_UPD;
					else if (!seg_q) begin seg_q <= 1'b1; st_q <= S_VST; end
					else st_q <= S_DST;
				end
				S_DST: st_q <= S_DIV;
				S_DIV: if (sts.div_last) st_q <= S_EMIT;
				S_UPD: begin
					// first two points: update points first, then emit if any; later points emitted already
					if (sts.end_flag && (seen_q == 2'd0 || seen_q == 2'd1)) st_q <= S_EMIT;
					else if (seen_q == 2'd0) begin seen_q <= 2'd1; st_q <= S_IDLE; end
					else if (seen_q == 2'd1) begin seen_q <= 2'd2; st_q <= S_IDLE; end
					else begin
						st_q <= S_IDLE;
						seen_q <= sts.end_flag ? 2'd0 : 2'd3;
					end
				end
				S_EMIT: begin
					if (out_ready) begin
						emit_q <= emit_q + 2'd1;
						if (emit_last || (!sts.end_flag && ((seen_q == 2'd2 && emit_q == 2'd1)
							|| (seen_q == 2'd3 && emit_q == 2'd0)))) begin
							if (seen_q == 2'd0 || seen_q == 2'd1) begin
								seen_q <= 2'd0;
								st_q <= S_IDLE;
							end else st_q <= S_UPD;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;

	localparam longint PI30 = 64'sd3373259426;
	localparam int TAIL_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	phc_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	phc_pkg::out_word_t out_data;

	path_heading_curvature dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #10 clk = ~clk;

	// predictor state
	int pts_seen;
	longint old_x, old_y, new_x, new_y, held_head;

	phc_pkg::out_word_t expected_words[$];
	int errors = 0;
	int in_idle_pct = 37;
	int out_idle_pct = 54;
	bit hold_out = 0;
	bit done_stim = 0;
	int idle_cycles = 0;

	// directed words; check flag says row has typed-in results
	typedef struct {
		phc_pkg::in_word_t w;
		bit check;
		phc_pkg::out_word_t r0;
	} dir_row_t;
	dir_row_t dir_rows[$];

	function automatic void queue_word(phc_pkg::out_word_t o);
		expected_words.insert(expected_words.size(), o);
	endfunction

	function automatic void add_row(dir_row_t r);
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	function automatic longint sra(longint v, int s);
		return v >>> s;
	endfunction

	// CORDIC vectoring: Q30 angle and Q16.16 length
	task automatic seg_vector(input longint dx, input longint dy,
			output longint ang, output longint len);
		longint x, y, z, xs, ys;
		x = dx; y = dy; z = 0;
		if (dx == 0 && dy == 0) begin
			ang = 0; len = 0;
			return;
		end
		if (x < 0) begin
			z = (y >= 0) ? PI30 : -PI30;
			x = -x; y = -y;
		end
		for (int i = 0; i < phc_pkg::CordicStepsDef && i < 24; i++) begin
			xs = sra(x, i); ys = sra(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += longint'(phc_pkg::atan_tab(i[4:0]));
			end else begin
				x -= ys; y += xs; z -= longint'(phc_pkg::atan_tab(i[4:0]));
			end
		end
		ang = z;
		len = (x * 64'd10187994 + (64'd1 << 23)) >>> 24;
	endtask

	function automatic longint q30_to_q13(longint a);
		longint h;
		h = (a + 65536) >>> 17;
		if (h > 25736) h = 25736;
		if (h < -25736) h = -25736;
		return h;
	endfunction

	function automatic phc_pkg::out_word_t mk(longint h, longint c, bit l);
		phc_pkg::out_word_t o;
		o.heading = h[15:0];
		o.curvature = c[15:0];
		o.last_result = l;
		return o;
	endfunction

	task automatic reset_path();
		pts_seen = 0; old_x = 0; old_y = 0; new_x = 0; new_y = 0; held_head = 0;
	endtask

	// predict words caused by one accepted waypoint
	task automatic predict_point(input phc_pkg::in_word_t w);
		longint px, py, a_in, l_in, a_out, l_out, h_out, d, s, curv;
		px = longint'(w.point_x); py = longint'(w.point_y);
		curv = 0;
		if (pts_seen == 0) begin
			new_x = px; new_y = py;
			if (w.end_of_path) begin
				queue_word(mk(0, 0, 1));
				reset_path();
			end else pts_seen = 1;
			return;
		end
		if (pts_seen == 1) begin
			old_x = new_x; old_y = new_y; new_x = px; new_y = py;
			seg_vector(new_x - old_x, new_y - old_y, a_in, l_in);
			held_head = q30_to_q13(a_in);
			if (w.end_of_path) begin
				queue_word(mk(held_head, 0, 0));
				queue_word(mk(held_head, 0, 1));
				reset_path();
			end else pts_seen = 2;
			return;
		end
		seg_vector(new_x - old_x, new_y - old_y, a_in, l_in);
		seg_vector(px - new_x, py - new_y, a_out, l_out);
		h_out = q30_to_q13(a_out);
		if (!(new_x == old_x && new_y == old_y) && !(px == new_x && py == new_y)) begin
			d = a_out - a_in;
			if (d > PI30) d -= 2 * PI30;
			if (d < -PI30) d += 2 * PI30;
			if (d < 0) d = -d;
			s = l_in + l_out;
			if (s == 0) s = 1;
			curv = (d + 4 * s) / (8 * s);
			if (curv > 65535) curv = 65535;
		end
		if (pts_seen == 2) queue_word(mk(held_head, curv, 0));
		queue_word(mk(h_out, curv, 0));
		if (w.end_of_path) begin
			queue_word(mk(h_out, curv, 1));
			reset_path();
			return;
		end
		old_x = new_x; old_y = new_y; new_x = px; new_y = py;
		held_head = h_out; pts_seen = 3;
	endtask

	function automatic phc_pkg::in_word_t pt(int x, int y, bit l);
		phc_pkg::in_word_t w;
		w.point_x = x; w.point_y = y; w.end_of_path = l;
		return w;
	endfunction

	// send one waypoint with random idling
	task automatic send_point(input phc_pkg::in_word_t w);
		while ($urandom_range(99) < in_idle_pct) @(posedge clk);
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_point(w);
		in_valid <= 1'b0;
		// block is busy right after an accept, so this costs no throughput
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	// random waypoint: mostly small steps, some full-range noise
	function automatic phc_pkg::in_word_t rand_point(longint bx, longint by, bit l);
		phc_pkg::in_word_t w;
		int r;
		r = $urandom_range(99);
		if (r < 10) begin
			w.point_x = $urandom; w.point_y = $urandom;
		end else if (r < 15) begin
			w.point_x = bx[31:0]; w.point_y = by[31:0];
		end else begin
			w.point_x = 32'(bx + $signed($urandom_range(8000000)) - 4000000);
			w.point_y = 32'(by + $signed($urandom_range(8000000)) - 4000000);
		end
		w.end_of_path = l;
		return w;
	endfunction

	task automatic send_random_paths(input int n_items);
		int sent, plen;
		phc_pkg::in_word_t w;
		longint bx, by;
		sent = 0;
		while (sent < n_items) begin
			plen = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
			bx = longint'($signed($urandom));
			by = longint'($signed($urandom));
			for (int k = 0; k < plen; k++) begin
				w = rand_point(bx, by, k == plen - 1);
				bx = longint'(w.point_x); by = longint'(w.point_y);
				send_point(w);
				sent++;
			end
		end
	endtask

	// receiver: random stalls, optional long hold-off
	always @(posedge clk) begin
		if (hold_out) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(99) >= out_idle_pct);
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word %p", out_data);
			end else begin
				if (out_data !== expected_words[0]) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %p actual %p", expected_words[0],
							out_data);
				end
				void'(expected_words.pop_front());
			end
		end
	end

	// watchdog on accepted-nothing cycles
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) idle_cycles <= 0;
		else if (!done_stim || expected_words.size() != 0) idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		dir_row_t r;
		reset_path();
		// single point, two points, extremes, zero-length segments
		add_row('{pt(32'sh7fffffff, 32'sh80000000, 1), 1, mk(0, 0, 1)});
		add_row('{pt(0, 0, 0), 0, '0});
		add_row('{pt(65536, 0, 1), 0, '0});
		add_row('{pt(32'sh80000000, 32'sh80000000, 0), 0, '0});
		add_row('{pt(32'sh7fffffff, 32'sh7fffffff, 0), 0, '0});
		add_row('{pt(32'sh80000000, 32'sh7fffffff, 0), 0, '0});
		add_row('{pt(32'sh80000000, 32'sh80000000, 1), 0, '0});
		add_row('{pt(5, 5, 0), 0, '0});
		add_row('{pt(5, 5, 0), 0, '0});
		add_row('{pt(5, 5, 1), 0, '0});
		add_row('{pt(0, 0, 0), 0, '0});
		add_row('{pt(1, 0, 0), 0, '0});
		add_row('{pt(1, 1, 0), 0, '0});
		add_row('{pt(0, 1, 0), 0, '0});
		add_row('{pt(-1, 0, 0), 0, '0});
		add_row('{pt(0, -1, 0), 0, '0});
		add_row('{pt(0, -1, 0), 0, '0});
		add_row('{pt(-65536, -1, 0), 0, '0});
		add_row('{pt(-131072, 0, 1), 0, '0});
		add_row('{pt(-1, -1, 1), 1, mk(0, 0, 1)});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			send_point(r.w);
			if (r.check && expected_words[expected_words.size() - 1] !== r.r0) begin
				errors++;
				$display("directed row %0d: predictor gives %p, table %p", i,
					expected_words[expected_words.size() - 1], r.r0);
			end
		end
		wait_drained();

		// fill up the block while the receiver holds off
		fork
			begin
				hold_out = 1;
				repeat (600) @(posedge clk);
				hold_out = 0;
			end
			send_random_paths(15);
		join
		wait_drained();

		send_random_paths(65);
		in_idle_pct = 54; out_idle_pct = 37;
		send_random_paths(65);
		wait_drained();
		in_idle_pct = 0; out_idle_pct = 0;
		send_random_paths(65);

		done_stim = 1;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule

// ----- filelist.f -----
src/phc_pkg.sv
src/phc_datapath.sv
src/phc_ctrl.sv
src/path_heading_curvature.sv
sim/tb.sv
